// File: rtl/ms_pkg.sv
// ----------------------------------------------------------------------------
// ms_pkg: shared types for the merge sorter
// Word layouts of both channels and the command that the front hands
// to the back through the queue.
// ----------------------------------------------------------------------------
package ms_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = 6;
  localparam int CNT_W       = 7;

  typedef struct packed {
    logic signed [31:0] value;
    logic               final_item;
  } item_t;

  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last_result;
    logic               truncated;
  } result_t;

  typedef struct packed {
    logic [31:0]       value;
    logic [ADDR_W-1:0] addr;
    logic              store;
    logic              final_item;
    logic              trunc;
    logic [CNT_W-1:0]  n;
  } cmd_t;

endpackage

// File: rtl/ms_ram.sv
// ----------------------------------------------------------------------------
// ms_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/ms_queue.sv
// ----------------------------------------------------------------------------
// ms_queue: short command queue between front and back
// Small circular buffer; push when not full, pop when not empty.
// ----------------------------------------------------------------------------
module ms_queue #(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  ms_pkg::cmd_t push_data,
  output logic         full,
  input  logic         pop,
  output ms_pkg::cmd_t pop_data,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  ms_pkg::cmd_t       entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [FILL_W-1:0]  fill;

  assign full     = (fill == FILL_W'(DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: rtl/ms_front.sv
// ----------------------------------------------------------------------------
// ms_front: input side of the merge sorter
// Counts words of the current set, marks words past capacity as dropped
// and turns each word into a command for the back.
// ----------------------------------------------------------------------------
module ms_front #(
  parameter int MAX_ITEMS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  ms_pkg::item_t item,
  input  logic          q_full,
  output logic          q_push,
  output ms_pkg::cmd_t  q_data
);

  logic [ms_pkg::CNT_W-1:0] count;
  logic                     overflow;
  logic                     store;

  assign item_ready = !q_full;
  assign q_push     = item_valid && !q_full;
  assign store      = (count < ms_pkg::CNT_W'(MAX_ITEMS));

  always_comb begin
    q_data            = '0;
    q_data.value      = item.value;
    q_data.addr       = count[ms_pkg::ADDR_W-1:0];
    q_data.store      = store;
    q_data.final_item = item.final_item;
    q_data.trunc      = overflow || !store;
    q_data.n          = store ? count + 1'b1 : count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (q_push) begin
      if (item.final_item) begin
        count    <= '0;
        overflow <= 1'b0;
      end else if (store) begin
        count <= count + 1'b1;
      end else begin
        overflow <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/ms_back.sv
// ----------------------------------------------------------------------------
// ms_back: storage, merge engine and result output of the merge sorter
// Loads words into RAM A, runs bottom-up merge passes ping-ponging
// between RAM A and RAM B, then streams the sorted run out.
// ----------------------------------------------------------------------------
module ms_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  output logic            q_pop,
  input  ms_pkg::cmd_t    q_data,
  output logic            result_valid,
  input  logic            result_ready,
  output ms_pkg::result_t result
);

  localparam int CW = ms_pkg::CNT_W;
  localparam int AW = ms_pkg::ADDR_W;

  typedef enum logic [2:0] {
    S_IDLE, S_RUN, S_HEAD_A, S_HEAD_B, S_CMP, S_REFILL, S_EMIT_RD, S_EMIT_WAIT
  } state_t;

  state_t             state;
  logic [CW-1:0]      n, width, lo, mid, hi, i, j, k;
  logic               trunc, src, took_a;
  logic signed [31:0] head_a, head_b;

  logic               a_we, b_we, a_re, b_re;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [31:0]        wr_data, a_rd, b_rd, rd_data;

  logic [CW-1:0]      two_w, run_end, mid_sum, mid_c, hi_c;
  logic               take_a;
  logic               emit_go;

  assign two_w   = width << 1;
  assign run_end = lo + two_w;
  assign mid_sum = lo + width;
  assign mid_c   = (mid_sum > n) ? n : mid_sum;
  assign hi_c    = (run_end > n) ? n : run_end;
  assign take_a  = (i < mid) && ((j >= hi) || (head_a <= head_b));
  assign rd_data = src ? b_rd : a_rd;
  assign q_pop   = (state == S_IDLE) && !q_empty;
  assign emit_go = (state == S_EMIT_WAIT) && (!result_valid || result_ready);

  always_comb begin
    a_we    = 1'b0;
    b_we    = 1'b0;
    wr_addr = k[AW-1:0];
    wr_data = take_a ? head_a : head_b;
    a_re    = 1'b0;
    b_re    = 1'b0;
    rd_addr = k[AW-1:0];
    unique case (state)
      S_IDLE: begin
        a_we    = q_pop && q_data.store;
        wr_addr = q_data.addr;
        wr_data = q_data.value;
      end
      S_RUN: begin
        rd_addr = lo[AW-1:0];
        a_re    = !src;
        b_re    = src;
      end
      S_HEAD_A: begin
        rd_addr = j[AW-1:0];
        a_re    = !src;
        b_re    = src;
      end
      S_CMP: begin
        a_we = src;
        b_we = !src;
        rd_addr = take_a ? AW'(i + 1'b1) : AW'(j + 1'b1);
        a_re    = !src;
        b_re    = src;
      end
      S_EMIT_RD: begin
        a_re = !src;
        b_re = src;
      end
      default: begin
      end
    endcase
  end

  ms_ram #(.WIDTH(32), .DEPTH(ms_pkg::STORE_DEPTH)) u_ram_a (
    .clk     (clk),
    .wr_en   (a_we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (a_re),
    .rd_addr (rd_addr),
    .rd_data (a_rd)
  );

  ms_ram #(.WIDTH(32), .DEPTH(ms_pkg::STORE_DEPTH)) u_ram_b (
    .clk     (clk),
    .wr_en   (b_we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (b_re),
    .rd_addr (rd_addr),
    .rd_data (b_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (emit_go) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop && q_data.final_item) begin
            n     <= q_data.n;
            trunc <= q_data.trunc;
            width <= CW'(1);
            src   <= 1'b0;
            lo    <= '0;
            k     <= '0;
            state <= (q_data.n == CW'(1)) ? S_EMIT_RD : S_RUN;
          end
        end
        S_RUN: begin
          mid   <= mid_c;
          hi    <= hi_c;
          i     <= lo;
          j     <= mid_c;
          k     <= lo;
          state <= S_HEAD_A;
        end
        S_HEAD_A: begin
          head_a <= $signed(rd_data);
          state  <= S_HEAD_B;
        end
        S_HEAD_B: begin
          head_b <= $signed(rd_data);
          state  <= S_CMP;
        end
        S_CMP: begin
          took_a <= take_a;
          if (take_a) begin
            i <= i + 1'b1;
          end else begin
            j <= j + 1'b1;
          end
          if (k + 1'b1 == hi) begin
            if (run_end >= n) begin
              src   <= !src;
              width <= two_w;
              lo    <= '0;
              k     <= '0;
              state <= (two_w >= n) ? S_EMIT_RD : S_RUN;
            end else begin
              k     <= k + 1'b1;
              lo    <= run_end;
              state <= S_RUN;
            end
          end else begin
            k     <= k + 1'b1;
            state <= S_REFILL;
          end
        end
        S_REFILL: begin
          if (took_a) begin
            head_a <= $signed(rd_data);
          end else begin
            head_b <= $signed(rd_data);
          end
          state <= S_CMP;
        end
        S_EMIT_RD: begin
          state <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          if (emit_go) begin
            result.sorted_value <= $signed(rd_data);
            result.last_result  <= (k + 1'b1 == n);
            result.truncated    <= trunc;
            k                   <= k + 1'b1;
            state               <= (k + 1'b1 == n) ? S_IDLE : S_EMIT_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_cmp_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (k < hi))
    else $error("merge output index past end of run");

  a_cmp_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> ((i < mid) || (j < hi)))
    else $error("merge step with both halves exhausted");

  a_cmp_balance: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (k == CW'(i + j - mid)))
    else $error("merge output index out of step with read indices");

  a_emit_holds_queue: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !q_pop)
    else $error("queue popped while sort or emit in progress");

endmodule

// File: rtl/merge_sorter_unit.sv
// ----------------------------------------------------------------------------
// merge_sorter_unit: stable ascending sort of a set of signed 32-bit values
// Words enter on the item channel (valid/ready); the word with final_item
// set closes the set. Up to MAX_ITEMS values are kept; later values of the
// same set are dropped and every result of that set has truncated set.
// Results leave on the result channel in ascending order, ties in arrival
// order, last_result set on the greatest value.
// A non-final word passes the front, which builds its command combinationally,
// and a queue of QUEUE_DEPTH commands to the back, which writes it to RAM A while idle.
// After the final word the back runs ceil(log2 n) merge passes; each run is
// set up in S_RUN, S_HEAD_A and S_HEAD_B and each element is merged in S_CMP
// and S_REFILL, the last of a run in S_CMP alone (one RAM read port,
// registered read data). Each result is read in S_EMIT_RD and handed out in
// S_EMIT_WAIT.
// Reset clears the counters, the queue and the sequencer; RAM contents stay
// undefined and need no clearing pass. While the receiver stalls, output
// holds, the queue fills and then item_ready drops.
// ----------------------------------------------------------------------------
module merge_sorter_unit #(
  parameter int MAX_ITEMS   = 64,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  ms_pkg::item_t   item,
  output logic            result_valid,
  input  logic            result_ready,
  output ms_pkg::result_t result
);

  logic         q_full, q_push, q_pop, q_empty;
  ms_pkg::cmd_t q_in, q_out;

  ms_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  ms_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  ms_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_data       (q_out),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
